>>> design/rhc_pkg.sv
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types and fixed constants of the RGB/HSL colour converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

  // Restoring divider: one quotient bit per stage
  localparam int unsigned DIV_QW   = 17;
  // HSL to RGB datapath depth
  localparam int unsigned HSL_LAT  = 5;
  // Depth from input register to output register input
  localparam int unsigned PIPE_LAT = 1 + DIV_QW;

  typedef enum logic {
    OP_RGB2HSL = 1'b0,
    OP_HSL2RGB = 1'b1
  } op_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Hue in 1/64 degree: a full turn and its fractions
  localparam logic [14:0] TURN       = 15'd23040;
  localparam logic [14:0] THIRD      = 15'd7680;
  localparam logic [14:0] SIXTH      = 15'd3840;
  localparam logic [14:0] HALF_TURN  = 15'd11520;
  localparam logic [14:0] TWO_THIRDS = 15'd15360;

  // Q16 unity and half
  localparam logic [16:0] ONE_Q16  = 17'd65536;
  localparam logic [16:0] HALF_Q16 = 17'd32768;

endpackage

>>> design/rhc_div.sv
// ----------------------------------------------------------------------------
// rhc_div
// Pipelined restoring divider, one quotient bit per register stage.
// Expects num_i < (den_i << QW) and den_i != 0.
// ----------------------------------------------------------------------------
module rhc_div #(
  parameter int unsigned NW = 24,
  parameter int unsigned DW = 9,
  parameter int unsigned QW = 17
) (
  input  logic          clk,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_r [QW];
  logic [QW-1:0] low_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [DW-1:0] den_r [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] low_in;
    logic [QW-1:0] quo_in;
    logic [DW:0]   trial;
    logic          take;

    if (i == 0) begin : g_first
      assign rem_in = DW'(num_i[NW-1:QW]);
      assign low_in = num_i[QW-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign low_in = low_r[i-1];
      assign quo_in = quo_r[i-1];
      assign den_in = den_r[i-1];
    end

    // bring down the next numerator bit and trial-subtract
    assign trial = {rem_in, low_in[QW-1]};
    assign take  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      rem_r[i] <= take ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
      low_r[i] <= {low_in[QW-2:0], 1'b0};
      quo_r[i] <= {quo_in[QW-2:0], take};
      den_r[i] <= den_in;
    end
  end

  assign quo_o = quo_r[QW-1];

endmodule

>>> design/rhc_hsl2rgb.sv
// ----------------------------------------------------------------------------
// rhc_hsl2rgb
// Five-stage HSL to RGB datapath: clamp, helper levels, ramp, byte scale.
// ----------------------------------------------------------------------------
module rhc_hsl2rgb (
  input  logic          clk,
  input  logic [14:0]   hue_i,
  input  logic [16:0]   sat_i,
  input  logic [16:0]   light_i,
  output rhc_pkg::rgb_t rgb_o
);
  import rhc_pkg::*;

  // piecewise-linear ramp weight, 0..SIXTH
  function automatic logic [11:0] ramp(input logic [14:0] t);
    logic [11:0] k;
    if (t < SIXTH) begin
      k = t[11:0];
    end else if (t < HALF_TURN) begin
      k = SIXTH[11:0];
    end else if (t < TWO_THIRDS) begin
      k = 12'(TWO_THIRDS - t);
    end else begin
      k = '0;
    end
    return k;
  endfunction

  // stage A: clamp and hue shifts
  logic [16:0] s_cl, l_cl;
  logic [14:0] h_red, t_r, t_b;
  logic [15:0] t_r_sum;

  assign s_cl    = (sat_i > ONE_Q16) ? ONE_Q16 : sat_i;
  assign l_cl    = (light_i > ONE_Q16) ? ONE_Q16 : light_i;
  assign h_red   = (hue_i >= TURN) ? hue_i - TURN : hue_i;
  assign t_r_sum = 16'(h_red) + 16'(THIRD);
  assign t_r     = (t_r_sum >= 16'(TURN)) ? 15'(t_r_sum - 16'(TURN)) : t_r_sum[14:0];
  assign t_b     = (h_red >= THIRD) ? h_red - THIRD : h_red + TWO_THIRDS;

  logic [16:0] a_l_r, a_s_r, b_l_r, b_s_r;
  logic [11:0] a_k_r [3];
  logic [11:0] b_k_r [3];
  logic [11:0] c_k_r [3];
  logic [33:0] b_p_r;
  logic [32:0] c_diff_r, c_t2_r;
  logic [44:0] d_base_r;
  logic [44:0] d_m_r [3];
  logic [32:0] e_val;
  logic [44:0] num   [3];
  logic [48:0] scl   [3];
  logic [7:0]  byte_v[3];
  rgb_t        rgb_r;

  // stage C: t1 - (l << 16) folded into e
  assign e_val = (b_l_r < HALF_Q16) ? 33'(b_p_r)
                                    : 33'({b_s_r, 16'b0}) - 33'(b_p_r);

  always_ff @(posedge clk) begin
    a_l_r    <= l_cl;
    a_s_r    <= s_cl;
    a_k_r[0] <= ramp(t_r);
    a_k_r[1] <= ramp(h_red);
    a_k_r[2] <= ramp(t_b);
    b_p_r    <= 34'(a_l_r) * 34'(a_s_r);
    b_l_r    <= a_l_r;
    b_s_r    <= a_s_r;
    b_k_r    <= a_k_r;
    c_diff_r <= 33'({e_val, 1'b0});
    c_t2_r   <= 33'({b_l_r, 16'b0}) - e_val;
    c_k_r    <= b_k_r;
    d_base_r <= 45'({c_t2_r, 12'b0}) - 45'({c_t2_r, 8'b0});
    for (int i = 0; i < 3; i++) begin
      d_m_r[i] <= 45'(c_diff_r) * 45'(c_k_r[i]);
    end
    rgb_r <= {byte_v[0], byte_v[1], byte_v[2]};
  end

  // stage E: level * 255 / (SIXTH << 32) == level * 17 >> 40
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i]    = d_base_r + d_m_r[i];
      scl[i]    = 49'({num[i], 4'b0}) + 49'(num[i]);
      byte_v[i] = (scl[i][48:40] > 9'd255) ? 8'd255 : scl[i][47:40];
    end
  end

  assign rgb_o = rgb_r;

endmodule

>>> design/rgb_hsl_color_converter_core.sv
// ----------------------------------------------------------------------------
// rgb_hsl_color_converter_core
// Converts one pixel per clock between RGB bytes and Q16 HSL, either way.
// ----------------------------------------------------------------------------
//  channel  | ports                               | handshake
//  ---------+-------------------------------------+-----------------------------
//  input    | in_operation .. in_lightness        | transfer when start & !busy
//  result   | out_red_out .. out_lightness_out    | one-cycle strobe out_valid
//
//  A new pixel is taken every cycle; busy is never raised.
//  Each result passes through one input register, one min/max stage, 17
//  restoring-divider stages for saturation and hue (one quotient bit each) and
//  one output register. Lightness is a reciprocal multiply held in a delay
//  line of the same depth. The HSL to RGB path is five stages deep and is
//  delayed to match. The receiver cannot stall, so the pipeline never holds.
//  Reset clears the valid bits only; data registers carry no reset.
// ----------------------------------------------------------------------------
module rgb_hsl_color_converter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  input  logic [14:0] in_hue,
  input  logic [16:0] in_saturation,
  input  logic [16:0] in_lightness,
  output logic        out_valid,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic [7:0]  out_alpha_out,
  output logic [14:0] out_hue_out,
  output logic [16:0] out_saturation_out,
  output logic [16:0] out_lightness_out
);
  import rhc_pkg::*;

  localparam int unsigned DLY = PIPE_LAT - HSL_LAT;

  // never stall: every stage advances each cycle
  assign busy = 1'b0;

  // input register
  logic        vld0_r;
  logic        op0_r;
  logic [7:0]  r0_r, g0_r, b0_r, a0_r;
  logic [14:0] h0_r;
  logic [16:0] s0_r, l0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    op0_r <= in_operation;
    r0_r  <= in_red;
    g0_r  <= in_green;
    b0_r  <= in_blue;
    a0_r  <= in_alpha;
    h0_r  <= in_hue;
    s0_r  <= in_saturation;
    l0_r  <= in_lightness;
  end

  // sideband line: valid, direction and alpha ride alongside the datapaths
  logic       side_vld_r   [PIPE_LAT];
  logic       side_op_r    [PIPE_LAT];
  logic [7:0] side_alpha_r [PIPE_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_LAT; i++) begin
        side_vld_r[i] <= 1'b0;
      end
    end else begin
      side_vld_r[0] <= vld0_r;
      for (int i = 1; i < PIPE_LAT; i++) begin
        side_vld_r[i] <= side_vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    side_op_r[0]    <= op0_r;
    side_alpha_r[0] <= a0_r;
    for (int i = 1; i < PIPE_LAT; i++) begin
      side_op_r[i]    <= side_op_r[i-1];
      side_alpha_r[i] <= side_alpha_r[i-1];
    end
  end

  // RGB to HSL, stage 1: extremes, delta and sum
  logic [7:0] mx, mn;
  logic [7:0] r1_r, g1_r, b1_r, mx1_r, d1_r;
  logic [8:0] sum1_r;

  always_comb begin
    mx = r0_r;
    mn = r0_r;
    if (g0_r > mx) mx = g0_r;
    if (b0_r > mx) mx = b0_r;
    if (g0_r < mn) mn = g0_r;
    if (b0_r < mn) mn = b0_r;
  end

  always_ff @(posedge clk) begin
    r1_r   <= r0_r;
    g1_r   <= g0_r;
    b1_r   <= b0_r;
    mx1_r  <= mx;
    d1_r   <= mx - mn;
    sum1_r <= 9'(mx) + 9'(mn);
  end

  // stage 2: numerators and divisors; a grey pixel gives a zero numerator
  logic        grey;
  logic [8:0]  sat_den;
  logic [23:0] sat_num;
  logic [10:0] hue_m;
  logic [22:0] hue_num;
  logic [7:0]  hue_den;

  always_comb begin
    grey    = (d1_r == 8'd0);
    sat_num = {d1_r, 16'b0};
    if (grey) begin
      sat_den = 9'd1;
    end else if (sum1_r < 9'd255) begin
      sat_den = sum1_r;
    end else begin
      sat_den = 9'd510 - sum1_r;
    end
    // hue in sixths of a turn from the dominant channel, red checked first
    if (r1_r == mx1_r) begin
      if (g1_r >= b1_r) begin
        hue_m = 11'(g1_r) - 11'(b1_r);
      end else begin
        hue_m = 11'(d1_r) * 11'd6 + 11'(g1_r) - 11'(b1_r);
      end
    end else if (g1_r == mx1_r) begin
      hue_m = {2'b0, d1_r, 1'b0} + 11'(b1_r) - 11'(r1_r);
    end else begin
      hue_m = {1'b0, d1_r, 2'b0} + 11'(r1_r) - 11'(g1_r);
    end
    // times SIXTH: 4096 - 256
    hue_num = 23'({hue_m, 12'b0}) - 23'({hue_m, 8'b0});
    hue_den = grey ? 8'd1 : d1_r;
  end

  logic [DIV_QW-1:0] sat_q, hue_q;

  rhc_div #(.NW(24), .DW(9), .QW(DIV_QW)) u_div_sat (
    .clk   (clk),
    .num_i (sat_num),
    .den_i (sat_den),
    .quo_o (sat_q)
  );

  rhc_div #(.NW(23), .DW(8), .QW(DIV_QW)) u_div_hue (
    .clk   (clk),
    .num_i (hue_num),
    .den_i (hue_den),
    .quo_o (hue_q)
  );

  // lightness = sum * 32768 / 255 = sum * 128 + sum * 128 / 255; the last
  // term by reciprocal, y * 32897 >> 23, which is exact for y below 65536.
  // Hold it in a line as deep as the dividers.
  logic [15:0] lig_y;
  logic [31:0] lig_p;
  logic [16:0] lig_v;
  logic [16:0] lig_dly_r [DIV_QW];

  assign lig_y = {sum1_r, 7'b0};
  assign lig_p = 32'(lig_y) * 32'd32897;
  assign lig_v = 17'(lig_y) + 17'(lig_p[31:23]);

  always_ff @(posedge clk) begin
    lig_dly_r[0] <= lig_v;
    for (int i = 1; i < DIV_QW; i++) begin
      lig_dly_r[i] <= lig_dly_r[i-1];
    end
  end

  // HSL to RGB, then hold until the divider results catch up
  rgb_t hsl_rgb;
  rgb_t rgb_dly_r [DLY];

  rhc_hsl2rgb u_hsl2rgb (
    .clk     (clk),
    .hue_i   (h0_r),
    .sat_i   (s0_r),
    .light_i (l0_r),
    .rgb_o   (hsl_rgb)
  );

  always_ff @(posedge clk) begin
    rgb_dly_r[0] <= hsl_rgb;
    for (int i = 1; i < DLY; i++) begin
      rgb_dly_r[i] <= rgb_dly_r[i-1];
    end
  end

  // output register: zero the fields of the direction not chosen
  logic        out_vld_r;
  rgb_t        out_rgb_r;
  logic [7:0]  out_alpha_r;
  logic [14:0] out_hue_r;
  logic [16:0] out_sat_r, out_lig_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= side_vld_r[PIPE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    out_alpha_r <= side_alpha_r[PIPE_LAT-1];
    if (side_op_r[PIPE_LAT-1] == OP_HSL2RGB) begin
      out_rgb_r <= rgb_dly_r[DLY-1];
      out_hue_r <= '0;
      out_sat_r <= '0;
      out_lig_r <= '0;
    end else begin
      out_rgb_r <= '0;
      out_hue_r <= hue_q[14:0];
      out_sat_r <= sat_q;
      out_lig_r <= lig_dly_r[DIV_QW-1];
    end
  end

  assign out_valid          = out_vld_r;
  assign out_red_out        = out_rgb_r.red;
  assign out_green_out      = out_rgb_r.green;
  assign out_blue_out       = out_rgb_r.blue;
  assign out_alpha_out      = out_alpha_r;
  assign out_hue_out        = out_hue_r;
  assign out_saturation_out = out_sat_r;
  assign out_lightness_out  = out_lig_r;

  // only one direction may carry non-zero fields
  a_dir_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_red_out != 8'd0 || out_green_out != 8'd0 || out_blue_out != 8'd0)
    |-> out_hue_out == 15'd0 && out_saturation_out == 17'd0 && out_lightness_out == 17'd0)
    else $error("RGB and HSL fields both non-zero");

  // HSL results stay in range
  a_hsl_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue_out < TURN && out_saturation_out <= ONE_Q16
                  && out_lightness_out <= ONE_Q16)
    else $error("HSL result out of range");

  // a coloured pixel cannot be black
  a_sat_light: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturation_out != 17'd0 |-> out_lightness_out != 17'd0)
    else $error("saturation without lightness");

endmodule
